[rtl/core/woadr_pkg.sv]
// Package with the widths, command codes, result kinds, configuration indices and the queue entry type.
package woadr_pkg;

    localparam int TempW  = 16;
    localparam int TimeW  = 52;
    localparam int AddrW  = 32;
    localparam int PortW  = 16;
    localparam int CountW = 7;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 52;

    typedef enum logic [1:0] {
        CMD_READING  = 2'd0,
        CMD_FIRE     = 2'd1,
        CMD_REGISTER = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_CONFIRM = 2'd1,
        KIND_OPEN    = 2'd2,
        KIND_SPARE   = 2'd3
    } t_kind;

    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_NEEDED    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW    = 2'd2;

    // Work item passed from the classifier to the executor.
    typedef struct packed {
        t_cmd              cmd;
        logic              hot;
        logic [TimeW-1:0]  sample_time;
        logic [TimeW-1:0]  now_time;
        logic [AddrW-1:0]  gate_addr;
        logic [PortW-1:0]  gate_port;
    } t_job;

endpackage

[rtl/core/woadr_if.sv]
// Valid/ready channel interfaces for events and results.
interface woadr_in_if;
    import woadr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic signed [TempW-1:0] temperature;
    logic [TimeW-1:0]        sample_time;
    logic [TimeW-1:0]        now_time;
    logic [AddrW-1:0]        gate_addr;
    logic [PortW-1:0]        gate_port;
    modport source (output valid, command, temperature, sample_time, now_time,
                    gate_addr, gate_port, input ready);
    modport sink   (input valid, command, temperature, sample_time, now_time,
                    gate_addr, gate_port, output ready);
endinterface

interface woadr_out_if;
    import woadr_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [AddrW-1:0]  target_address;
    logic [PortW-1:0]  target_port;
    logic              alarm_active;
    logic [CountW-1:0] window_count;
    logic              last;
    modport source (output valid, kind, target_address, target_port, alarm_active,
                    window_count, last, input ready);
    modport sink   (input valid, kind, target_address, target_port, alarm_active,
                    window_count, last, output ready);
endinterface

[rtl/core/woadr_front.sv]
// Front end: takes events, compares readings to the threshold and queues jobs.
module woadr_front #(
    parameter int QDEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    woadr_in_if.sink                  in_ch,
    input  logic signed [woadr_pkg::TempW-1:0] i_threshold,
    output logic                      o_job_valid,
    output woadr_pkg::t_job           o_job,
    input  logic                      i_job_pop
);
    import woadr_pkg::*;

    localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_job            r_q [QDEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_cnt;
    t_job            n_job;
    logic            push;

    assign in_ch.ready = (r_cnt != (PtrW+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];

    always_comb begin
        n_job.cmd          = t_cmd'(in_ch.command);
        n_job.hot          = (in_ch.temperature >= i_threshold);
        n_job.sample_time  = in_ch.sample_time;
        n_job.now_time     = in_ch.now_time;
        n_job.gate_addr    = in_ch.gate_addr;
        n_job.gate_port    = in_ch.gate_port;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_job_pop) begin
                r_rd <= (r_rd == PtrW'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(i_job_pop);
        end
    end

endmodule

[rtl/core/woadr_back.sv]
// Back end: detection window, door table and result generation.
module woadr_back #(
    parameter int DETECT_SLOTS = 64,
    parameter int DOOR_SLOTS   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  woadr_pkg::t_job              i_job,
    output logic                         o_job_pop,
    input  logic [woadr_pkg::CountW-1:0] i_needed,
    input  logic [woadr_pkg::TimeW-1:0]  i_window,
    woadr_out_if.source                  out_ch
);
    import woadr_pkg::*;

    localparam int DPW  = (DETECT_SLOTS > 1) ? $clog2(DETECT_SLOTS) : 1;
    localparam int DCW  = $clog2(DETECT_SLOTS + 1);
    localparam int RPW  = (DOOR_SLOTS > 1) ? $clog2(DOOR_SLOTS) : 1;
    localparam int RCW  = $clog2(DOOR_SLOTS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRUNE = 7'b0000010,
        ST_RDWT  = 7'b0000100,
        ST_APPEND= 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_FAN   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    // Detection FIFO as a circular memory: head pointer plus count.
    logic [TimeW-1:0] r_det [DETECT_SLOTS];
    logic [AddrW-1:0] r_adr [DOOR_SLOTS];
    logic [PortW-1:0] r_prt [DOOR_SLOTS];

    t_state           r_state;
    t_job             r_job;
    logic [DPW-1:0]   r_head;
    logic [DCW-1:0]   r_total;
    logic [RCW-1:0]   r_doors;
    logic             r_alarm;
    logic [TimeW-1:0] r_cutoff;
    logic [DCW-1:0]   r_seen;
    logic [RCW-1:0]   r_idx;
    logic [TimeW-1:0] r_det_q;
    logic [AddrW-1:0] r_adr_q;
    logic [PortW-1:0] r_prt_q;
    logic             r_ovalid;
    logic [1:0]       r_okind;
    logic [AddrW-1:0] r_oaddr;
    logic [PortW-1:0] r_oport;
    logic             r_oalarm;
    logic [CountW-1:0] r_ocount;
    logic             r_olast;

    logic             out_free;
    logic [DPW-1:0]   tail;
    logic [DPW:0]     tail_sum;
    logic [DPW:0]     rd_sum;
    logic [DPW-1:0]   det_rd;

    assign out_free = !r_ovalid || out_ch.ready;
    assign tail_sum = {1'b0, r_head} + (DPW+1)'(r_total);
    assign tail = (tail_sum >= (DPW+1)'(DETECT_SLOTS)) ?
                  DPW'(tail_sum - (DPW+1)'(DETECT_SLOTS)) : DPW'(tail_sum);
    assign rd_sum = {1'b0, r_head} + (DPW+1)'(r_seen);
    assign det_rd = (rd_sum >= (DPW+1)'(DETECT_SLOTS)) ?
                    DPW'(rd_sum - (DPW+1)'(DETECT_SLOTS)) : DPW'(rd_sum);

    assign out_ch.valid          = r_ovalid;
    assign out_ch.kind           = r_okind;
    assign out_ch.target_address = r_oaddr;
    assign out_ch.target_port    = r_oport;
    assign out_ch.alarm_active   = r_oalarm;
    assign out_ch.window_count   = r_ocount;
    assign out_ch.last           = r_olast;
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    // Registered memory reads, and the writes to the window and the door table.
    always_ff @(posedge i_clk) begin
        r_det_q <= r_det[det_rd];
        r_adr_q <= r_adr[r_idx[RPW-1:0]];
        r_prt_q <= r_prt[r_idx[RPW-1:0]];
        if (r_state == ST_APPEND) begin
            r_det[tail] <= r_job.sample_time;
        end
        if (r_state == ST_SCAN && r_idx == r_doors && r_doors != RCW'(DOOR_SLOTS)
            && out_free) begin
            r_adr[r_idx[RPW-1:0]] <= r_job.gate_addr;
            r_prt[r_idx[RPW-1:0]] <= r_job.gate_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_total  <= '0;
            r_doors  <= '0;
            r_alarm  <= 1'b0;
            r_ovalid <= 1'b0;
            r_seen   <= '0;
            r_idx    <= '0;
        end else begin
            if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job    <= i_job;
                        r_cutoff <= i_job.now_time - i_window;
                        r_seen   <= '0;
                        r_idx    <= '0;
                        case (i_job.cmd)
                            CMD_READING: begin
                                if (!i_job.hot) begin
                                    r_state <= ST_EMIT;
                                end else if (i_job.now_time >= i_window) begin
                                    r_state <= ST_PRUNE;
                                end else begin
                                    r_state <= ST_APPEND;
                                end
                            end
                            CMD_FIRE:     r_state <= ST_FAN;
                            CMD_REGISTER: r_state <= ST_SCAN;
                            default:      r_state <= ST_EMIT;
                        endcase
                    end
                end
                ST_PRUNE: begin
                    // Issue a read of the oldest entry not yet checked.
                    if (r_seen == r_total) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_state <= ST_RDWT;
                    end
                end
                ST_RDWT: begin
                    if (r_det_q < r_cutoff) begin
                        r_head  <= (r_head == DPW'(DETECT_SLOTS-1)) ? '0 : r_head + 1'b1;
                        r_total <= r_total - 1'b1;
                        r_state <= ST_PRUNE;
                    end else begin
                        r_state <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    if (r_total == DCW'(DETECT_SLOTS)) begin
                        // Full: the new entry overwrites the oldest slot.
                        r_head <= (r_head == DPW'(DETECT_SLOTS-1)) ? '0 : r_head + 1'b1;
                        if (DCW'(DETECT_SLOTS) >= DCW'(i_needed)) begin
                            r_state <= ST_FAN;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_total <= r_total + 1'b1;
                        if ((r_total + 1'b1) >= DCW'(i_needed)) begin
                            r_state <= ST_FAN;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_SCAN: begin
                    // Each table entry in turn: address it, then compare the registered read.
                    if (r_seen[0] == 1'b0) begin
                        if (r_idx == r_doors) begin
                            if (r_doors != RCW'(DOOR_SLOTS) && out_free) begin
                                r_doors  <= r_doors + 1'b1;
                                r_ovalid <= 1'b1;
                                r_okind  <= KIND_CONFIRM;
                                r_oaddr  <= r_job.gate_addr;
                                r_oport  <= r_job.gate_port;
                                r_oalarm <= r_alarm;
                                r_ocount <= CountW'(r_total);
                                r_olast  <= 1'b1;
                                r_state  <= ST_IDLE;
                            end else if (r_doors == RCW'(DOOR_SLOTS)) begin
                                r_state <= ST_EMIT;
                            end
                        end else begin
                            r_seen[0] <= 1'b1;
                        end
                    end else begin
                        r_seen[0] <= 1'b0;
                        if (r_adr_q == r_job.gate_addr && r_prt_q == r_job.gate_port) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_FAN: begin
                    r_alarm <= 1'b1;
                    if (r_doors == '0) begin
                        r_state <= ST_EMIT;
                    end else if (r_seen[0] == 1'b0) begin
                        r_seen[0] <= 1'b1;
                    end else if (out_free) begin
                        r_seen[0] <= 1'b0;
                        r_ovalid  <= 1'b1;
                        r_okind   <= KIND_OPEN;
                        r_oaddr   <= r_adr_q;
                        r_oport   <= r_prt_q;
                        r_oalarm  <= 1'b1;
                        r_ocount  <= CountW'(r_total);
                        r_olast   <= (r_idx + 1'b1 == r_doors);
                        r_idx     <= r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_doors) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_STATUS;
                        r_oaddr  <= '0;
                        r_oport  <= '0;
                        r_oalarm <= r_alarm;
                        r_ocount <= CountW'(r_total);
                        r_olast  <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/windowed_overtemp_alarm_door_registry.sv]
// Top level of the over-temperature alarm with detection window and door table.
//
//  Channel   Dir  Handshake        Contents
//  in_ch     in   valid/ready      command, temperature, times, door
//  out_ch    out  valid/ready      kind, target door, alarm, count, last
//  cfg       in   i_cfg_we only    threshold, detections needed, window
//
// A reading at or above the threshold is taken from the queue; while pruning,
// each window entry examined is addressed and its registered read compared;
// then the detection is appended and its status result loaded. A fan-out
// loads an open result per registered door from the registered door-table read
// port in place of the status result; a fire report goes to the fan-out. A
// registration compares each table entry's read. Output stalls delay all these.
// Synchronous reset sets counts, pointers, state, latch and config, no sweep.
// A two-entry job queue lets events transfer in while the back end works,
// and the output register holds a result until its transfer completes.
module windowed_overtemp_alarm_door_registry #(
    parameter int DETECT_SLOTS = 64,
    parameter int DOOR_SLOTS   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    woadr_in_if.sink                       in_ch,
    woadr_out_if.source                    out_ch,
    input  logic                           i_cfg_we,
    input  logic [woadr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [woadr_pkg::CfgDataW-1:0] i_cfg_data
);
    import woadr_pkg::*;

    logic signed [TempW-1:0] r_threshold;
    logic [CountW-1:0]       r_needed;
    logic [TimeW-1:0]        r_window;
    logic                    job_valid;
    logic                    job_pop;
    t_job                    job;

    // Configuration registers; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_needed    <= CountW'(1);
            r_window    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[TempW-1:0];
                CFG_NEEDED:    r_needed    <= i_cfg_data[CountW-1:0];
                CFG_WINDOW:    r_window    <= i_cfg_data[TimeW-1:0];
                default: ;
            endcase
        end
    end

    woadr_front #(.QDEPTH(2)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .i_threshold (r_threshold),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    woadr_back #(.DETECT_SLOTS(DETECT_SLOTS), .DOOR_SLOTS(DOOR_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_needed    (r_needed),
        .i_window    (r_window),
        .out_ch      (out_ch)
    );

    // The back end never pops a job from an empty queue.
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid) else $error("job popped from empty queue");

    // An open-door result always reports the alarm latched.
    a_open_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.kind == KIND_OPEN) |-> out_ch.alarm_active)
        else $error("open command without alarm");

    // Status results are always the final result of their event.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.kind == KIND_STATUS) |-> out_ch.last)
        else $error("status result not last");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the over-temperature alarm with detection window and door table.
`timescale 1ns / 1ps

module testbench;
    import woadr_pkg::*;

    localparam int DetectSlots = 64;
    localparam int DoorSlots   = 32;
    localparam int CycleLimit  = 400000;
    localparam int SettleCycles = 300;

    // One expected result transfer on the output channel.
    typedef struct {
        t_kind             kind;
        logic [AddrW-1:0]  addr;
        logic [PortW-1:0]  port;
        logic              alarm;
        logic [CountW-1:0] count;
        logic              last;
    } t_alarm_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    woadr_in_if  in_ch ();
    woadr_out_if out_ch ();

    windowed_overtemp_alarm_door_registry #(
        .DETECT_SLOTS(DetectSlots),
        .DOOR_SLOTS  (DoorSlots)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the block's state and registers, kept in step with every
    // accepted event.
    logic [TimeW-1:0]         detect_times [DetectSlots];
    int                       detect_count;
    logic [AddrW-1:0]         door_addrs [DoorSlots];
    logic [PortW-1:0]         door_ports [DoorSlots];
    int                       doors_held;
    logic                     alarm_latched;
    logic signed [TempW-1:0]  threshold;
    logic [CountW-1:0]        needed;
    logic [TimeW-1:0]         window_us;

    t_alarm_result pending_results[$];
    int            errors;
    int            cycles;
    int            ready_hold;   // receiver holds ready low while this is nonzero
    bit            no_gaps;      // both sides run without idling
    logic [TimeW-1:0] clock_us;  // running time base for random events
    logic [AddrW-1:0] used_addrs[$];
    logic [PortW-1:0] used_ports[$];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------
    function automatic void push_result(t_kind kind, logic [AddrW-1:0] addr,
                                        logic [PortW-1:0] port);
        t_alarm_result r;
        r.kind  = kind;
        r.addr  = addr;
        r.port  = port;
        r.alarm = alarm_latched;
        r.count = detect_count[CountW-1:0];
        r.last  = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Latches the alarm and queues one open command per registered door.
    function automatic int open_all_doors();
        alarm_latched = 1'b1;
        for (int i = 0; i < doors_held; i++)
            push_result(KIND_OPEN, door_addrs[i], door_ports[i]);
        return doors_held;
    endfunction

    function automatic void predict_event(t_cmd cmd, logic signed [TempW-1:0] temp,
                                          logic [TimeW-1:0] sample_us,
                                          logic [TimeW-1:0] now_us,
                                          logic [AddrW-1:0] addr,
                                          logic [PortW-1:0] port);
        int produced;
        int drop;
        bit known;
        logic [TimeW-1:0] cutoff;
        produced = 0;
        drop = 0;
        known = 0;
        case (cmd)
            CMD_READING: begin
                if (temp >= threshold) begin
                    // Pruning only applies once the current time has reached
                    // the window length.
                    if (now_us >= window_us) begin
                        cutoff = now_us - window_us;
                        while (drop < detect_count && detect_times[drop] < cutoff)
                            drop++;
                    end
                    if (drop == 0 && detect_count >= DetectSlots)
                        drop = 1;
                    for (int i = 0; i < detect_count - drop; i++)
                        detect_times[i] = detect_times[i + drop];
                    detect_count -= drop;
                    detect_times[detect_count] = sample_us;
                    detect_count++;
                    if (detect_count >= needed)
                        produced = open_all_doors();
                end
            end
            CMD_FIRE: begin
                produced = open_all_doors();
            end
            CMD_REGISTER: begin
                for (int i = 0; i < doors_held; i++)
                    if (door_addrs[i] == addr && door_ports[i] == port)
                        known = 1;
                if (!known && doors_held < DoorSlots) begin
                    door_addrs[doors_held] = addr;
                    door_ports[doors_held] = port;
                    doors_held++;
                    push_result(KIND_CONFIRM, addr, port);
                    produced = 1;
                end
            end
            default: ;
        endcase
        if (produced == 0)
            push_result(KIND_STATUS, '0, '0);
        pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Result side: checks each transfer and drives ready.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alarm_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d addr %h",
                         $time, out_ch.kind, out_ch.target_address);
            end else begin
                exp_r = pending_results.pop_front();
                if (out_ch.kind !== exp_r.kind) begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d",
                             $time, exp_r.kind, out_ch.kind);
                end
                if (out_ch.target_address !== exp_r.addr) begin
                    errors++;
                    $display("%0t: target_address expected %h actual %h",
                             $time, exp_r.addr, out_ch.target_address);
                end
                if (out_ch.target_port !== exp_r.port) begin
                    errors++;
                    $display("%0t: target_port expected %h actual %h",
                             $time, exp_r.port, out_ch.target_port);
                end
                if (out_ch.alarm_active !== exp_r.alarm) begin
                    errors++;
                    $display("%0t: alarm_active expected %b actual %b",
                             $time, exp_r.alarm, out_ch.alarm_active);
                end
                if (out_ch.window_count !== exp_r.count) begin
                    errors++;
                    $display("%0t: window_count expected %0d actual %0d",
                             $time, exp_r.count, out_ch.window_count);
                end
                if (out_ch.last !== exp_r.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b",
                             $time, exp_r.last, out_ch.last);
                end
            end
        end
        // The long hold-off is counted here so the sender keeps offering
        // events while the output side is blocked.
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            out_ch.ready <= 1'b0;
        end else if (no_gaps) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= 33);
        end
    end

    // ---------------------------------------------------------------------
    // Event side
    // ---------------------------------------------------------------------
    // Offers one event and returns at the edge where its transfer happens.
    // Valid stays high afterwards so back-to-back events need no extra edge.
    task automatic send_event(t_cmd cmd, logic signed [TempW-1:0] temp,
                              logic [TimeW-1:0] sample_us, logic [TimeW-1:0] now_us,
                              logic [AddrW-1:0] addr, logic [PortW-1:0] port);
        if (!no_gaps && $urandom_range(99) < 33) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.temperature  <= temp;
        in_ch.sample_time  <= sample_us;
        in_ch.now_time     <= now_us;
        in_ch.gate_addr    <= addr;
        in_ch.gate_port    <= port;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_event(cmd, temp, sample_us, now_us, addr, port);
    endtask

    // Drops valid and waits until every expected result has come, then lets
    // the back end settle, since a result can leave before the block is idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Drives one register write; the caller drops the write enable afterwards.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD: threshold = value[TempW-1:0];
            CFG_NEEDED:    needed    = value[CountW-1:0];
            CFG_WINDOW:    window_us = value[TimeW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic signed [TempW-1:0] thr, logic [CountW-1:0] need,
                              logic [TimeW-1:0] win);
        drain();
        write_reg(CFG_THRESHOLD, {{(CfgDataW-TempW){thr[TempW-1]}}, thr});
        write_reg(CFG_NEEDED, CfgDataW'(need));
        write_reg(CFG_WINDOW, win);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [TimeW-1:0] rand_time();
        return TimeW'({$urandom, $urandom});
    endfunction

    // Random event: mostly readings near a moving time base, with fire
    // reports, registrations that sometimes repeat a door, and the unused code.
    task automatic send_random_event();
        int sel;
        logic signed [TempW-1:0] temp;
        logic [TimeW-1:0] sample_us;
        logic [TimeW-1:0] now_us;
        logic [AddrW-1:0] addr;
        logic [PortW-1:0] port;
        int pick;
        sel = $urandom_range(99);
        temp = TempW'($urandom);
        clock_us = clock_us + TimeW'($urandom_range(0, 30));
        now_us = clock_us;
        sample_us = now_us - TimeW'($urandom_range(0, 15));
        if ($urandom_range(9) == 0) begin
            now_us = rand_time();
            sample_us = rand_time();
        end
        addr = $urandom;
        port = PortW'($urandom);
        if (used_addrs.size() != 0 && $urandom_range(3) == 0) begin
            pick = $urandom_range(used_addrs.size() - 1);
            addr = used_addrs[pick];
            port = used_ports[pick];
        end else begin
            used_addrs.push_back(addr);
            used_ports.push_back(port);
        end
        if (sel < 55)
            send_event(CMD_READING, temp, sample_us, now_us, addr, port);
        else if (sel < 65)
            send_event(CMD_FIRE, temp, sample_us, now_us, addr, port);
        else if (sel < 80 && doors_held < 6)
            send_event(CMD_REGISTER, temp, sample_us, now_us, addr, port);
        else
            send_event(CMD_UNUSED, temp, sample_us, now_us, addr, port);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Defaults, early time, doors at the field extremes, duplicates, the
    // threshold extremes and the unused command.
    task automatic test_directed();
        // Below the reset threshold of zero: no detection.
        send_event(CMD_READING, -16'sd5, 52'd1, 52'd1, '0, '0);
        send_event(CMD_UNUSED, 16'sh7fff, '1, '1, '1, '1);
        send_event(CMD_REGISTER, 16'sd0, '0, '0, 32'h0000_0000, 16'h0000);
        send_event(CMD_REGISTER, 16'sd0, '0, '0, 32'hffff_ffff, 16'hffff);
        send_event(CMD_REGISTER, 16'sd0, '0, '0, 32'hffff_ffff, 16'hffff);
        send_event(CMD_REGISTER, 16'sd0, '0, '0, 32'hffff_ffff, 16'h0000);
        set_config(16'sd100, 7'd3, 52'd1000);
        // Current time below the window: no pruning yet.
        send_event(CMD_READING, 16'sd99, 52'd10, 52'd10, '0, '0);
        send_event(CMD_READING, 16'sd100, 52'd10, 52'd20, '0, '0);
        send_event(CMD_READING, 16'sd500, 52'd30, 52'd30, '0, '0);
        send_event(CMD_READING, 16'sh7fff, 52'd40, 52'd40, '0, '0);
        // Cutoff 1100 - 1000 = 100 prunes every entry older than 100.
        send_event(CMD_READING, 16'sd200, 52'd1100, 52'd1100, '0, '0);
        send_event(CMD_FIRE, -16'sd32768, '0, '0, '0, '0);
        set_config(-16'sd32768, 7'd64, '1);
        send_event(CMD_READING, -16'sd32768, '1, '1, '0, '0);
        send_event(CMD_READING, 16'sh7fff, '0, '1, '0, '0);
        set_config(16'sh7fff, 7'd1, 52'd0);
        send_event(CMD_READING, 16'sh7ffe, 52'd5, 52'd5, '0, '0);
        send_event(CMD_READING, 16'sh7fff, 52'd5, 52'd5, '0, '0);
        send_event(CMD_READING, 16'sh7fff, 52'd6, 52'd6, '0, '0);
        send_event(CMD_UNUSED, 16'sd0, '0, '0, '0, '0);
    endtask

    // Fills the detection window past its depth so the oldest entry drops,
    // with neither side idling.
    task automatic test_window_overflow();
        int i;
        i = 0;
        set_config(-16'sd32768, 7'd64, '1);
        no_gaps = 1;
        while (detect_count < DetectSlots) begin
            send_event(CMD_READING, TempW'($urandom), {20'd0, 32'(i)}, 52'd0, '0, '0);
            i++;
        end
        repeat (2) begin
            send_event(CMD_READING, TempW'($urandom), {20'd0, 32'(i)}, 52'd0, '0, '0);
            i++;
        end
        no_gaps = 0;
    endtask

    // Random events over several register settings.
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_config(16'sd0, 7'd2, 52'd40);
                1: set_config(TempW'($urandom), 7'($urandom_range(1, 6)),
                              52'($urandom_range(0, 80)));
                2: set_config(-16'sd1000, 7'd4, 52'd20);
                default: set_config(16'sd0, 7'd1, '1);
            endcase
            no_gaps = (phase == 2);
            for (int i = 0; i < 2; i++)
                send_random_event();
        end
        no_gaps = 0;
    endtask

    // The receiver blocks for a long stretch while events keep coming, then
    // the sender waits for every result before going on.
    task automatic test_backpressure();
        drain();
        ready_hold = 400;
        for (int i = 0; i < 6; i++)
            send_random_event();
        drain();
        for (int i = 0; i < 2; i++)
            send_random_event();
    endtask

    // Fills the door table to capacity, offers one more registration, then a fire report opens all.
    task automatic test_door_table_full();
        while (doors_held < DoorSlots)
            send_event(CMD_REGISTER, TempW'($urandom), rand_time(), rand_time(),
                       $urandom, PortW'($urandom));
        send_event(CMD_REGISTER, TempW'($urandom), rand_time(), rand_time(),
                   $urandom, PortW'($urandom));
        send_event(CMD_FIRE, 16'sd0, '0, '0, '0, '0);
        set_config(16'sd0, 7'd1, 52'd0);
        send_event(CMD_READING, 16'sd1, 52'd7, 52'd7, '0, '0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.command = CMD_READING;
        in_ch.temperature = '0;
        in_ch.sample_time = '0;
        in_ch.now_time = '0;
        in_ch.gate_addr = '0;
        in_ch.gate_port = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        cycles = 0;
        ready_hold = 0;
        no_gaps = 0;
        clock_us = 52'd100;
        detect_count = 0;
        doors_held = 0;
        alarm_latched = 1'b0;
        threshold = '0;
        needed = 7'd1;
        window_us = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_window_overflow();
        test_random();
        test_backpressure();
        test_door_table_full();
        drain();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[windowed_overtemp_alarm_door_registry.f]
rtl/core/woadr_pkg.sv
rtl/core/woadr_if.sv
rtl/core/woadr_front.sv
rtl/core/woadr_back.sv
rtl/core/windowed_overtemp_alarm_door_registry.sv
tb/sv/testbench.sv
